@@ hw/rtl/dsh_pkg.sv @@
package dsh_pkg;

    localparam int GridW     = 256;
    localparam int GridH     = 256;
    localparam int ColW      = $clog2(GridW);
    localparam int RowW      = $clog2(GridH);
    localparam int AddrW     = ColW + RowW;
    localparam int CellW     = 24;
    localparam int SeedFuzz  = 16;
    localparam int AmpW      = 32;
    localparam logic [3:0] OctReset = 4'd4;
    localparam logic [3:0] OctMax   = 4'(ColW);

    typedef enum logic [0:0] {
        ACT_GEN  = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED,
        ST_SQ_R0,
        ST_SQ_R1,
        ST_SQ_R2,
        ST_SQ_R3,
        ST_SQ_W0,
        ST_SQ_W1,
        ST_DM_R0,
        ST_DM_R1,
        ST_DM_R2,
        ST_DM_R3,
        ST_DM_R4,
        ST_DM_R5,
        ST_DM_W0,
        ST_DM_W1,
        ST_DM_W2,
        ST_NEXT,
        ST_RD,
        ST_DONE
    } state_t;

    function automatic logic [31:0] xs32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    function automatic logic [7:0] to_level(input logic signed [CellW-1:0] v);
        logic signed [CellW-1:0] q;
        logic signed [CellW-1:0] t;
        // truncate toward zero: bias negatives before the shift
        q = (v + (v[CellW-1] ? CellW'(511) : CellW'(0))) >>> 9;
        t = q + CellW'(128);
        if (t[CellW-1])
            return 8'd0;
        else if (t > CellW'(255))
            return 8'd255;
        else
            return t[7:0];
    endfunction

endpackage

@@ hw/rtl/diamond_square_height_field_top.sv @@
// Read item: the memory read is registered, then ST_RD registers level and the result
//   strobe; busy covers the read, so no new read is accepted before the strobe.
// Generate item: a seed pass, then per level a square pass (ST_SQ_R0..R3, W0, W1)
//   and a diamond pass (ST_DM_R0..R5, W0..W2, ST_NEXT), paced by the one read and one
//   write memory port. Result strobe with was_read=0 when done.
// Reset clears control, generator word (1) and oct_reg (4); grid memory
//   is not cleared and reads before the first generate return undefined data.
module diamond_square_height_field_top import dsh_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [0:0]  action,
    input  logic [31:0] seed,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    output logic        strobe,
    output logic [7:0]  level,
    output logic        was_read,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    state_t state_reg, state_next;

    logic [3:0]       oct_reg;
    logic [ColW:0]    step_reg, step_next;     // holds GridW itself
    logic [ColW-1:0]  x_reg, x_next;
    logic [RowW-1:0]  y_reg, y_next;
    logic signed [CellW+2:0] acc_reg, acc_next;   // sum of four cells
    logic signed [CellW+2:0] acc2_reg, acc2_next; // Y-edge sum
    logic signed [CellW-1:0] mx_reg, mx_next;
    logic        strobe_reg, strobe_next;
    logic [7:0]  level_reg, level_next;
    logic        wr_reg, wr_next;

    // memory port
    logic                    m_we;
    logic [AddrW-1:0]        m_waddr, m_raddr;
    logic [CellW-1:0]        m_wdata, m_rdata;

    logic        rng_load, rng_adv;
    logic [31:0] rng_word, rng_new;

    logic [3:0]       oct_eff;
    logic [ColW:0]    half;
    logic [ColW:0]    sinit;
    logic [AmpW-1:0]  amp;
    logic signed [AmpW:0] disp;
    logic signed [CellW-1:0] seedval;
    logic signed [CellW-1:0] avg, avg2;
    logic signed [CellW+2:0] rd_ext;
    logic        last_x, last_y;

    dsh_ram #(.Width(CellW), .Depth(GridW * GridH)) u_ram (
        .clk  (clk),
        .we   (m_we),
        .waddr(m_waddr),
        .wdata(m_wdata),
        .raddr(m_raddr),
        .rdata(m_rdata)
    );

    dsh_rng u_rng (
        .clk  (clk),
        .rst_n(rst_n),
        .load (rng_load),
        .seed (seed),
        .adv  (rng_adv),
        .word (rng_word)
    );

    assign oct_eff  = (oct_reg > OctMax) ? OctMax : oct_reg;
    assign sinit    = (ColW+1)'(GridW) >> oct_eff;
    assign half     = step_reg >> 1;
    assign rng_new  = xs32(rng_word);
    // amp = 256 * (step << oct); draw in 0..2*amp-1 minus amp
    assign amp      = AmpW'(step_reg) << (8 + oct_eff);
    assign disp     = $signed({1'b0, rng_new & ((amp << 1) - AmpW'(1))}) - $signed({1'b0, amp});
    assign seedval  = CellW'(($signed({1'b0, rng_new[7:0]}) - 9'sd128) * SeedFuzz);
    assign rd_ext   = (CellW+3)'($signed(m_rdata));
    // signed divide by 4 toward zero
    assign avg  = CellW'((acc_reg + (acc_reg[CellW+2] ? (CellW+3)'(3) : (CellW+3)'(0))) >>> 2);
    assign avg2 = CellW'((acc2_reg + (acc2_reg[CellW+2] ? (CellW+3)'(3) : (CellW+3)'(0))) >>> 2);
    assign last_x = ((ColW+1)'(x_reg) + step_reg) >= (ColW+1)'(GridW);
    assign last_y = ((RowW+1)'(y_reg) + (RowW+1)'(step_reg)) >= (RowW+1)'(GridH);

    function automatic logic [AddrW-1:0] ad(input logic [ColW:0] c, input logic [RowW:0] r);
        return {r[RowW-1:0], c[ColW-1:0]};
    endfunction

    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oct_reg <= OctReset;
        else if (cfg_valid && cfg_ready)
            oct_reg <= cfg_data;
    end

    always_comb
    begin
        logic [ColW:0] xc;
        logic [RowW:0] yc;
        logic [ColW:0] hc;
        xc = (ColW+1)'(x_reg);
        yc = (RowW+1)'(y_reg);
        hc = half;
        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        acc2_next   = acc2_reg;
        mx_next     = mx_reg;
        strobe_next = 1'b0;
        level_next  = level_reg;
        wr_next     = wr_reg;
        m_we        = 1'b0;
        m_waddr     = ad(xc, yc);
        m_wdata     = '0;
        m_raddr     = ad(xc, yc);
        rng_load    = 1'b0;
        rng_adv     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_READ)
                    begin
                        m_raddr   = {row[RowW-1:0], col[ColW-1:0]};
                        state_next = ST_RD;
                    end
                    else
                    begin
                        rng_load   = 1'b1;
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ST_SEED;
                    end
                end
            end
            ST_RD:
            begin
                strobe_next = 1'b1;
                wr_next     = 1'b1;
                level_next  = to_level($signed(m_rdata));
                state_next  = ST_IDLE;
            end
            ST_SEED:
            begin
                m_we    = 1'b1;
                m_wdata = seedval;
                rng_adv = 1'b1;
                x_next  = ColW'(xc + sinit);
                if (((ColW+1)'(x_reg) + sinit) >= (ColW+1)'(GridW))
                begin
                    x_next = '0;
                    y_next = RowW'(yc + (RowW+1)'(sinit));
                    if (((RowW+1)'(y_reg) + (RowW+1)'(sinit)) >= (RowW+1)'(GridH))
                    begin
                        y_next    = '0;
                        step_next = sinit;
                        state_next = (sinit > 1) ? ST_SQ_R0 : ST_DONE;
                    end
                end
            end
            // square (centre) pass: read four corners
            ST_SQ_R0: begin m_raddr = ad(xc, yc);                         state_next = ST_SQ_R1; end
            ST_SQ_R1: begin m_raddr = ad(xc, yc + (RowW+1)'(step_reg));  acc_next = rd_ext;
                            state_next = ST_SQ_R2; end
            ST_SQ_R2: begin m_raddr = ad(xc + step_reg, yc);              acc_next = acc_reg + rd_ext;
                            state_next = ST_SQ_R3; end
            ST_SQ_R3: begin m_raddr = ad(xc + step_reg, yc + (RowW+1)'(step_reg));
                            acc_next = acc_reg + rd_ext; state_next = ST_SQ_W0; end
            ST_SQ_W0: begin acc_next = acc_reg + rd_ext; state_next = ST_SQ_W1; end
            ST_SQ_W1:
            begin
                m_we    = 1'b1;
                m_waddr = ad(xc + hc, yc + (RowW+1)'(hc));
                m_wdata = CellW'($signed(avg) + disp);
                rng_adv = 1'b1;
                x_next  = ColW'(xc + step_reg);
                state_next = ST_SQ_R0;
                if (last_x)
                begin
                    x_next = '0;
                    y_next = RowW'(yc + (RowW+1)'(step_reg));
                    if (last_y)
                    begin
                        y_next = '0;
                        state_next = ST_DM_R0;
                    end
                end
            end
            // diamond (edge) pass: v, vx, vy, hxp, hyp, h
            ST_DM_R0: begin m_raddr = ad(xc, yc); state_next = ST_DM_R1; end
            ST_DM_R1: begin m_raddr = ad(xc + step_reg, yc);
                            acc_next = rd_ext; acc2_next = rd_ext; state_next = ST_DM_R2; end
            ST_DM_R2: begin m_raddr = ad(xc, yc + (RowW+1)'(step_reg));
                            acc_next = acc_reg + rd_ext; state_next = ST_DM_R3; end
            ST_DM_R3: begin m_raddr = ad(xc + hc, yc + (RowW+1)'(hc) - (RowW+1)'(step_reg));
                            acc2_next = acc2_reg + rd_ext; state_next = ST_DM_R4; end
            ST_DM_R4: begin m_raddr = ad(xc + hc - step_reg, yc + (RowW+1)'(hc));
                            acc_next = acc_reg + rd_ext; state_next = ST_DM_R5; end
            ST_DM_R5: begin m_raddr = ad(xc + hc, yc + (RowW+1)'(hc));
                            acc2_next = acc2_reg + rd_ext; state_next = ST_DM_W0; end
            ST_DM_W0:
            begin
                acc_next  = acc_reg + rd_ext;
                acc2_next = acc2_reg + rd_ext;
                state_next = ST_DM_W1;
            end
            ST_DM_W1:
            begin
                mx_next = CellW'($signed(avg) + disp);
                rng_adv = 1'b1;
                state_next = ST_DM_W2;
            end
            ST_DM_W2:
            begin
                // write the X edge; build the Y edge from the next draw into mx
                m_we    = 1'b1;
                m_waddr = ad(xc + hc, yc);
                m_wdata = mx_reg;
                mx_next = CellW'($signed(avg2) + disp);
                rng_adv = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                // write the Y edge built in ST_DM_W2
                m_we    = 1'b1;
                m_waddr = ad(xc, yc + (RowW+1)'(hc));
                m_wdata = mx_reg;
                x_next  = ColW'(xc + step_reg);
                state_next = ST_DM_R0;
                if (last_x)
                begin
                    x_next = '0;
                    y_next = RowW'(yc + (RowW+1)'(step_reg));
                    if (last_y)
                    begin
                        y_next    = '0;
                        step_next = step_reg >> 1;
                        state_next = (step_reg > 2) ? ST_SQ_R0 : ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                wr_next     = 1'b0;
                level_next  = '0;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        acc2_reg  <= acc2_next;
        mx_reg    <= mx_next;
        level_reg <= level_next;
        wr_reg    <= wr_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign level    = level_reg;
    assign was_read = wr_reg;

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> state_reg == ST_IDLE)
        else $error("result strobe outside idle");
    a_read_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && action == ACT_READ) |=> ##1 strobe_reg && wr_reg)
        else $error("read result missing");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("config open while busy");
endmodule

@@ hw/rtl/dsh_ram.sv @@
module dsh_ram #(
    parameter int Width = 24,
    parameter int Depth = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/dsh_rng.sv @@
module dsh_rng import dsh_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [31:0] seed,
    input  logic        adv,
    output logic [31:0] word
);
    logic [31:0] word_reg;
    logic [31:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (load)
            word_next = (seed == 32'd0) ? 32'd1 : seed;
        else if (adv)
            word_next = xs32(word_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= 32'd1;
        else
            word_reg <= word_next;
    end

    assign word = word_reg;

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n) word_reg != 32'd0)
        else $error("rng word reached zero");
endmodule
